>>> hw/rtl/ffba_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the first-fit block allocator.
// No dependencies; imported by ffba_table, first_fit_block_allocator, ffba_checker and tb_top.
package ffba_pkg;

   localparam int ADDR_W = 23;
   localparam int SIZE_W = 12;
   localparam int MODE_W = 2;
   localparam int TID_W  = 4;
   localparam int STAT_W = 3;

   localparam logic [SIZE_W-1:0] AREA_BYTES = 12'd4095;

   localparam logic [MODE_W-1:0] MODE_SHARED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_THREAD = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FREE   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SETUP  = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
   localparam logic [STAT_W-1:0] ST_BAD_SIZE   = 3'd1;
   localparam logic [STAT_W-1:0] ST_HEAP_FULL  = 3'd2;
   localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd3;
   localparam logic [STAT_W-1:0] ST_AREA       = 3'd4;
   localparam logic [STAT_W-1:0] ST_BAD_FREE   = 3'd5;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] length;
      logic              is_free;
   } entry_type;

endpackage

>>> hw/rtl/ffba_table.sv
`timescale 1ns / 1ps
// Block table memory: one write port, one registered read port.
// Depends on ffba_pkg for the entry layout.
module ffba_table #(
   parameter int DEPTH = 256
) (
   input  logic                                             clock,
   input  logic                                             wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     wr_idx,
   input  ffba_pkg::entry_type                              wr_entry,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     rd_idx,
   output ffba_pkg::entry_type                              rd_entry
);
   import ffba_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
      rd_entry_ff <= mem[rd_idx];
   end

   assign rd_entry = rd_entry_ff;

endmodule

>>> hw/rtl/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// First-fit heap allocator with per-thread bump areas.
// Depends on ffba_pkg and ffba_table.
//
// One request word is taken at a time; req_stall stays high until its result is
// in the output register. A shared alloc, area setup or free walks the block table
// one entry a cycle through its single read port and stops at the first match or
// at the end of the table. A thread-local alloc goes through S_AREA; a rejected
// request, or a free of address zero, goes straight to S_DONE. The result register
// lets the next request in while a finished result still waits on rsp_stall.
module first_fit_block_allocator #(
   parameter int HEAP_BYTES       = 8388608,
   parameter int MAX_BLOCKS       = 256,
   parameter int MAX_THREAD_AREAS = 16,
   parameter int META_BYTES       = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ffba_pkg::MODE_W-1:0]      req_mode,
   input  logic [ffba_pkg::SIZE_W-1:0]      req_size,
   input  logic [ffba_pkg::ADDR_W-1:0]      req_address_in,
   input  logic [ffba_pkg::TID_W-1:0]       req_thread_id,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ffba_pkg::ADDR_W-1:0]      rsp_address_out,
   output logic [ffba_pkg::STAT_W-1:0]      rsp_status
);
   import ffba_pkg::*;

   localparam int BIW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW      = $clog2(MAX_BLOCKS + 1);
   localparam int HT_W    = $clog2(HEAP_BYTES + 1);
   localparam int NW      = HT_W + 1;
   localparam int AIW     = (MAX_THREAD_AREAS > 1) ? $clog2(MAX_THREAD_AREAS) : 1;
   localparam int FW      = ADDR_W + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_AREA = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [MODE_W-1:0]       mode_ff, mode_in;
   logic [SIZE_W-1:0]       size_ff, size_in;
   logic [ADDR_W-1:0]       addr_in_ff, addr_in_in;
   logic [TID_W-1:0]        tid_ff, tid_in;
   logic [CW-1:0]           rd_idx_ff, rd_idx_in;
   logic                    chk_valid_ff, chk_valid_in;
   logic [BIW-1:0]          chk_idx_ff, chk_idx_in;
   logic [CW-1:0]           block_count_ff, block_count_in;
   logic [HT_W-1:0]         heap_top_ff, heap_top_in;
   logic [MAX_THREAD_AREAS-1:0] area_valid_ff, area_valid_in;
   logic [ADDR_W-1:0]       res_addr_ff, res_addr_in;
   logic [STAT_W-1:0]       res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]       rsp_addr_ff, rsp_addr_in;
   logic [STAT_W-1:0]       rsp_status_ff, rsp_status_in;

   logic                    tbl_wr_en;
   logic [BIW-1:0]          tbl_wr_idx;
   entry_type               tbl_wr_entry;
   entry_type               tbl_rd_entry;

   logic [ADDR_W+SIZE_W-1:0] area_mem [MAX_THREAD_AREAS];
   logic [ADDR_W+SIZE_W-1:0] area_rd_ff;
   logic                     area_wr_en;
   logic [AIW-1:0]           area_wr_idx;
   logic [ADDR_W+SIZE_W-1:0] area_wr_data;
   logic [AIW-1:0]           area_rd_idx;

   logic                    accept;
   logic                    req_tid_ok;
   logic                    issue;
   logic                    alloc_hit;
   logic                    free_hit;
   logic [NW-1:0]           need;
   logic                    heap_full;
   logic                    table_full;
   logic [ADDR_W-1:0]       top_data_addr;
   logic [ADDR_W-1:0]       hit_data_addr;
   logic [ADDR_W-1:0]       area_base;
   logic [SIZE_W-1:0]       area_used;
   logic [SIZE_W:0]         area_sum;

   ffba_table #(
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock    (clock),
      .wr_en    (tbl_wr_en),
      .wr_idx   (tbl_wr_idx),
      .wr_entry (tbl_wr_entry),
      .rd_idx   (rd_idx_ff[BIW-1:0]),
      .rd_entry (tbl_rd_entry)
   );

   assign accept      = req_valid && !req_stall;
   assign req_stall   = (state_ff != S_IDLE);
   assign req_tid_ok  = (32'(req_thread_id) < MAX_THREAD_AREAS);
   assign area_rd_idx = AIW'(req_thread_id);

   assign issue     = (rd_idx_ff < block_count_ff);
   assign alloc_hit = tbl_rd_entry.is_free && (tbl_rd_entry.length >= size_ff);
   assign free_hit  = ((FW'(tbl_rd_entry.start) + FW'(META_BYTES)) == FW'(addr_in_ff));
   assign hit_data_addr = tbl_rd_entry.start + ADDR_W'(META_BYTES);

   assign need       = NW'(heap_top_ff) + NW'(size_ff) + NW'(META_BYTES);
   assign heap_full  = (need > NW'(HEAP_BYTES));
   assign table_full = (block_count_ff == CW'(MAX_BLOCKS));
   assign top_data_addr = ADDR_W'(heap_top_ff) + ADDR_W'(META_BYTES);

   assign area_base = area_rd_ff[ADDR_W+SIZE_W-1:SIZE_W];
   assign area_used = area_rd_ff[SIZE_W-1:0];
   assign area_sum  = {1'b0, area_used} + {1'b0, size_ff};

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      size_in        = size_ff;
      addr_in_in     = addr_in_ff;
      tid_in         = tid_ff;
      rd_idx_in      = rd_idx_ff;
      chk_valid_in   = 1'b0;
      chk_idx_in     = chk_idx_ff;
      block_count_in = block_count_ff;
      heap_top_in    = heap_top_ff;
      area_valid_in  = area_valid_ff;
      res_addr_in    = res_addr_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_status_in  = rsp_status_ff;
      tbl_wr_en      = 1'b0;
      tbl_wr_idx     = chk_idx_ff;
      tbl_wr_entry   = tbl_rd_entry;
      area_wr_en     = 1'b0;
      area_wr_idx    = AIW'(tid_ff);
      area_wr_data   = area_rd_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in       = req_mode;
               addr_in_in    = req_address_in;
               tid_in        = req_thread_id;
               size_in       = (req_mode == MODE_SETUP) ? AREA_BYTES : req_size;
               rd_idx_in     = '0;
               res_addr_in   = '0;
               res_status_in = ST_OK;
               case (req_mode)
                  MODE_SHARED: begin
                     if (req_size == '0) begin
                        res_status_in = ST_BAD_SIZE;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  MODE_THREAD: begin
                     if (req_size == '0) begin
                        res_status_in = ST_BAD_SIZE;
                        state_in      = S_DONE;
                     end else if (!req_tid_ok || !area_valid_ff[AIW'(req_thread_id)]) begin
                        res_status_in = ST_AREA;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_AREA;
                     end
                  end
                  MODE_FREE: begin
                     if (req_address_in == '0) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     if (!req_tid_ok) begin
                        res_status_in = ST_AREA;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end

         S_AREA: begin
            if (area_sum > {1'b0, AREA_BYTES}) begin
               res_status_in = ST_AREA;
            end else begin
               res_addr_in  = area_base + ADDR_W'(area_used);
               area_wr_en   = 1'b1;
               area_wr_data = {area_base, area_sum[SIZE_W-1:0]};
            end
            state_in = S_DONE;
         end

         S_SCAN: begin
            if (chk_valid_ff && (mode_ff == MODE_FREE) && free_hit) begin
               if (tbl_rd_entry.is_free) begin
                  res_status_in = ST_BAD_FREE;
               end else begin
                  tbl_wr_en            = 1'b1;
                  tbl_wr_entry.is_free = 1'b1;
               end
               state_in = S_DONE;
            end else if (chk_valid_ff && (mode_ff != MODE_FREE) && alloc_hit) begin
               tbl_wr_en            = 1'b1;
               tbl_wr_entry.is_free = 1'b0;
               res_addr_in          = hit_data_addr;
               if (mode_ff == MODE_SETUP) begin
                  area_wr_en              = 1'b1;
                  area_wr_data            = {hit_data_addr, {SIZE_W{1'b0}}};
                  area_valid_in[AIW'(tid_ff)] = 1'b1;
               end
               state_in = S_DONE;
            end else if (!chk_valid_ff && !issue) begin
               if (mode_ff == MODE_FREE) begin
                  res_status_in = ST_BAD_FREE;
               end else if (heap_full) begin
                  res_status_in = ST_HEAP_FULL;
               end else if (table_full) begin
                  res_status_in = ST_TABLE_FULL;
               end else begin
                  tbl_wr_en            = 1'b1;
                  tbl_wr_idx           = block_count_ff[BIW-1:0];
                  tbl_wr_entry.start   = ADDR_W'(heap_top_ff);
                  tbl_wr_entry.length  = size_ff;
                  tbl_wr_entry.is_free = 1'b0;
                  block_count_in       = block_count_ff + 1'b1;
                  heap_top_in          = need[HT_W-1:0];
                  res_addr_in          = top_data_addr;
                  if (mode_ff == MODE_SETUP) begin
                     area_wr_en              = 1'b1;
                     area_wr_data            = {top_data_addr, {SIZE_W{1'b0}}};
                     area_valid_in[AIW'(tid_ff)] = 1'b1;
                  end
               end
               state_in = S_DONE;
            end else if (issue) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_idx_ff[BIW-1:0];
               rd_idx_in    = rd_idx_ff + 1'b1;
            end
         end

         default: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (area_wr_en) begin
         area_mem[area_wr_idx] <= area_wr_data;
      end
      area_rd_ff <= area_mem[area_rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         chk_valid_ff   <= 1'b0;
         block_count_ff <= '0;
         heap_top_ff    <= '0;
         area_valid_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         chk_valid_ff   <= chk_valid_in;
         block_count_ff <= block_count_in;
         heap_top_ff    <= heap_top_in;
         area_valid_ff  <= area_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      size_ff       <= size_in;
      addr_in_ff    <= addr_in_in;
      tid_ff        <= tid_in;
      rd_idx_ff     <= rd_idx_in;
      chk_idx_ff    <= chk_idx_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_address_out = rsp_addr_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

>>> tb/ffba_checker.sv
`timescale 1ns / 1ps
// Checker for first_fit_block_allocator: watches the request and result channels, keeps
// its own copy of the block table and thread areas, and compares every result word.
// Depends on ffba_pkg; instantiated beside the block by tb_top.
module ffba_checker #(
   parameter int HEAP_BYTES       = 8388608,
   parameter int MAX_BLOCKS       = 256,
   parameter int MAX_THREAD_AREAS = 16,
   parameter int META_BYTES       = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [ffba_pkg::MODE_W-1:0] req_mode,
   input  logic [ffba_pkg::SIZE_W-1:0] req_size,
   input  logic [ffba_pkg::ADDR_W-1:0] req_address_in,
   input  logic [ffba_pkg::TID_W-1:0]  req_thread_id,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [ffba_pkg::ADDR_W-1:0] rsp_address_out,
   input  logic [ffba_pkg::STAT_W-1:0] rsp_status,
   output int                          fail_count,
   output int                          pending
);
   import ffba_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [STAT_W-1:0] status;
   } result_type;

   result_type        expected_results[$];
   result_type        want;
   logic [ADDR_W-1:0] blk_start  [MAX_BLOCKS];
   logic [SIZE_W-1:0] blk_length [MAX_BLOCKS];
   logic              blk_free   [MAX_BLOCKS];
   int                blk_count;
   int                heap_top;
   logic [ADDR_W-1:0] area_base  [MAX_THREAD_AREAS];
   logic [SIZE_W-1:0] area_used  [MAX_THREAD_AREAS];
   logic              area_valid [MAX_THREAD_AREAS];
   int                fails;
   int                a;

   function automatic logic [STAT_W-1:0] take_block(input int size,
                                                    output logic [ADDR_W-1:0] address);
      longint need;
      int     i;
      address = '0;
      for (i = 0; i < blk_count; i++) begin
         if (blk_free[i] && int'(blk_length[i]) >= size) begin
            blk_free[i] = 1'b0;
            address = ADDR_W'(int'(blk_start[i]) + META_BYTES);
            return ST_OK;
         end
      end
      need = longint'(heap_top) + size + META_BYTES;
      if (need > HEAP_BYTES)
         return ST_HEAP_FULL;
      if (blk_count >= MAX_BLOCKS)
         return ST_TABLE_FULL;
      blk_start[blk_count]  = ADDR_W'(heap_top);
      blk_length[blk_count] = SIZE_W'(size);
      blk_free[blk_count]   = 1'b0;
      blk_count++;
      address  = ADDR_W'(heap_top + META_BYTES);
      heap_top = int'(need);
      return ST_OK;
   endfunction

   function automatic logic [STAT_W-1:0] release_block(input logic [ADDR_W-1:0] address);
      int i;
      if (address == '0)
         return ST_OK;
      for (i = 0; i < blk_count; i++) begin
         if (longint'(blk_start[i]) + META_BYTES == longint'(address)) begin
            if (blk_free[i])
               return ST_BAD_FREE;
            blk_free[i] = 1'b1;
            return ST_OK;
         end
      end
      return ST_BAD_FREE;
   endfunction

   function automatic result_type predict_result(input logic [MODE_W-1:0] mode,
                                                 input logic [SIZE_W-1:0] size,
                                                 input logic [ADDR_W-1:0] address_in,
                                                 input logic [TID_W-1:0]  tid);
      result_type        res;
      logic [ADDR_W-1:0] base;
      res.status  = ST_OK;
      res.address = '0;
      case (mode)
         MODE_SHARED: begin
            if (size == '0)
               res.status = ST_BAD_SIZE;
            else
               res.status = take_block(int'(size), res.address);
         end
         MODE_THREAD: begin
            if (size == '0)
               res.status = ST_BAD_SIZE;
            else if (int'(tid) >= MAX_THREAD_AREAS || !area_valid[tid])
               res.status = ST_AREA;
            else if (int'(area_used[tid]) + int'(size) > int'(AREA_BYTES))
               res.status = ST_AREA;
            else begin
               res.address    = area_base[tid] + ADDR_W'(area_used[tid]);
               area_used[tid] = area_used[tid] + size;
            end
         end
         MODE_FREE: begin
            res.status = release_block(address_in);
         end
         default: begin
            if (int'(tid) >= MAX_THREAD_AREAS)
               res.status = ST_AREA;
            else begin
               res.status = take_block(int'(AREA_BYTES), base);
               if (res.status == ST_OK) begin
                  area_base[tid]  = base;
                  area_used[tid]  = '0;
                  area_valid[tid] = 1'b1;
                  res.address     = base;
               end
            end
         end
      endcase
      if (res.status != ST_OK)
         res.address = '0;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         blk_count = 0;
         heap_top  = 0;
         for (a = 0; a < MAX_THREAD_AREAS; a++)
            area_valid[a] = 1'b0;
         fails = 0;
         pending    <= 0;
         fail_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result word: address_out %0h status %0d",
                      rsp_address_out, rsp_status);
               fails++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_address_out !== want.address) begin
                  $error("address_out: expected %0h, actual %0h", want.address,
                         rsp_address_out);
                  fails++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fails++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(predict_result(req_mode, req_size, req_address_in,
                                                      req_thread_id));
         pending    <= expected_results.size();
         fail_count <= fails;
      end
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the first_fit_block_allocator testbench: clock, reset, request and result
// stall stimulus, and the verdict. Depends on ffba_pkg, ffba_checker and the block.
module tb_top;
   import ffba_pkg::*;

   localparam int HEAP_BYTES       = 8388608;
   localparam int MAX_BLOCKS       = 256;
   localparam int MAX_THREAD_AREAS = 16;
   localparam int META_BYTES       = 24;
   localparam int RANDOM_WORDS     = 950;
   localparam int DRAIN_CYCLES     = 300;
   localparam int CYCLE_LIMIT      = 2000000;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic [MODE_W-1:0] req_mode        = '0;
   logic [SIZE_W-1:0] req_size        = '0;
   logic [ADDR_W-1:0] req_address_in  = '0;
   logic [TID_W-1:0]  req_thread_id   = '0;
   logic              rsp_stall       = 1'b0;
   logic              steady          = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic [ADDR_W-1:0] rsp_address_out;
   logic [STAT_W-1:0] rsp_status;
   int                fail_count;
   int                pending;
   int                cycle_count;
   int                n;
   logic [ADDR_W-1:0] handed_out[$];

   always #6 clock = ~clock;

   first_fit_block_allocator #(
      .HEAP_BYTES(HEAP_BYTES), .MAX_BLOCKS(MAX_BLOCKS),
      .MAX_THREAD_AREAS(MAX_THREAD_AREAS), .META_BYTES(META_BYTES)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_size(req_size), .req_address_in(req_address_in), .req_thread_id(req_thread_id),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_address_out(rsp_address_out),
      .rsp_status(rsp_status)
   );

   ffba_checker #(
      .HEAP_BYTES(HEAP_BYTES), .MAX_BLOCKS(MAX_BLOCKS),
      .MAX_THREAD_AREAS(MAX_THREAD_AREAS), .META_BYTES(META_BYTES)
   ) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_size(req_size), .req_address_in(req_address_in), .req_thread_id(req_thread_id),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_address_out(rsp_address_out),
      .rsp_status(rsp_status), .fail_count(fail_count), .pending(pending)
   );

   // keep handed-out addresses as free targets
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && rsp_address_out != '0) begin
         handed_out.push_back(rsp_address_out);
         if (handed_out.size() > 400)
            void'(handed_out.pop_front());
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 15);
      return $urandom_range(30, 90);
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return SIZE_W'($urandom_range(1, 32));
      else if (r < 80)
         return SIZE_W'($urandom_range(0, 4095));
      return SIZE_W'($urandom_range(3968, 4095));
   endfunction

   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [SIZE_W-1:0] size,
                            input logic [ADDR_W-1:0] address, input logic [TID_W-1:0] tid);
      req_mode       <= mode;
      req_size       <= size;
      req_address_in <= address;
      req_thread_id  <= tid;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic send_random_word();
      int                r;
      int                k;
      logic [MODE_W-1:0] mode;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] address;
      logic [TID_W-1:0]  tid;
      r       = $urandom_range(0, 99);
      mode    = MODE_SHARED;
      size    = pick_size();
      address = ADDR_W'($urandom());
      tid     = TID_W'($urandom());
      if (r < 36) begin
         mode = MODE_SHARED;
      end else if (r < 58) begin
         mode = MODE_FREE;
         if (handed_out.size() > 0) begin
            k       = $urandom_range(0, handed_out.size() - 1);
            address = handed_out[k];
            if ($urandom_range(0, 9) < 7)
               handed_out.delete(k);
         end
      end else if (r < 62) begin
         mode = MODE_FREE;
         if ($urandom_range(0, 3) == 0)
            address = '0;
      end else if (r < 85) begin
         mode = MODE_THREAD;
         if ($urandom_range(0, 3) != 0)
            size = SIZE_W'($urandom_range(1, 300));
      end else if (r < 92) begin
         mode = MODE_SETUP;
      end else if (r < 96) begin
         mode = ($urandom_range(0, 1) == 0) ? MODE_SHARED : MODE_THREAD;
         size = '0;
      end else begin
         mode = MODE_W'($urandom());
         size = SIZE_W'($urandom());
      end
      send_word(mode, size, address, tid);
   endtask

   initial begin
      int r;
      int len;
      @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (steady) begin
            rsp_stall <= 1'b0;
            len = 1;
         end else if (r < 50) begin
            rsp_stall <= 1'b0;
            len = $urandom_range(1, 40);
         end else if (r < 90) begin
            rsp_stall <= 1'b1;
            len = $urandom_range(1, 3);
         end else if (r < 97) begin
            rsp_stall <= 1'b1;
            len = $urandom_range(4, 15);
         end else begin
            rsp_stall <= 1'b1;
            len = $urandom_range(30, 90);
         end
         repeat (len) @(posedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_word(MODE_SHARED, '0, '0, '0);
      send_word(MODE_THREAD, '0, '0, 4'd3);
      send_word(MODE_THREAD, 12'd12, '0, 4'd5);
      send_word(MODE_FREE, 12'd100, '0, '0);
      send_word(MODE_FREE, '0, '1, '1);
      send_word(MODE_SHARED, 12'd1, '0, '0);
      send_word(MODE_SHARED, 12'd4095, '0, '0);
      send_word(MODE_FREE, '0, 23'd24, '0);
      send_word(MODE_FREE, '0, 23'd24, '0);
      send_word(MODE_SHARED, 12'd1, '1, '1);
      send_word(MODE_FREE, '0, 23'd49, '0);
      send_word(MODE_SHARED, 12'd100, '0, '0);
      send_word(MODE_SETUP, '1, '1, '0);
      send_word(MODE_THREAD, 12'd4095, '0, '0);
      send_word(MODE_THREAD, 12'd1, '0, '0);
      send_word(MODE_SETUP, '0, '0, 4'd15);
      send_word(MODE_THREAD, 12'd2000, '0, 4'd15);
      send_word(MODE_THREAD, 12'd2095, '0, 4'd15);
      send_word(MODE_THREAD, 12'd1, '0, 4'd15);
      send_word(MODE_SETUP, '0, '0, '0);
      send_word(MODE_THREAD, 12'd1, '0, '0);
      send_word(MODE_FREE, '0, 23'd50, '0);
      idle_sender(pick_gap());

      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 350 || n == 700) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending != 0);
         end
         if (n == 450)
            steady <= 1'b1;
         if (n == 550)
            steady <= 1'b0;
         send_random_word();
         if (!steady)
            idle_sender(pick_gap());
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
